// ===== design/nut_pkg.sv =====
// shared types and constants for the node use tracker
// used by nut_ctrl, nut_datapath and node_use_tracker; depends on nothing
package nut_pkg;

   localparam int unsigned ID_SPACE_DEF = 65536;
   localparam int unsigned KIND_W       = 2;
   localparam int unsigned ID_W         = 32;
   localparam int unsigned CNT_W        = 17;
   localparam int unsigned USE_W        = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // per-node use states
   localparam logic [USE_W-1:0] USE_NONE = 2'd0;
   localparam logic [USE_W-1:0] USE_ONCE = 2'd1;
   localparam logic [USE_W-1:0] USE_MANY = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   node_id;
   } nut_req_type;

   typedef struct packed {
      logic             used_twice;
      logic             out_of_range;
      logic [CNT_W-1:0] distinct_count;
      logic [CNT_W-1:0] repeat_count;
   } nut_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mem_read;
      logic update;
      logic sweep_write;
   } nut_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
   } nut_sts_type;

endpackage

// ===== design/node_use_tracker.sv =====
// Node use tracker: keeps a two-bit saturating use state per node id and
// counts distinct and repeated ids. A transaction is taken when start is high
// and busy is low; each transaction gives one result, shown on rsp_data for
// one cycle with rsp_strobe, and the receiver cannot hold it off. Mark, query
// and unused kinds pass a lookup read and an update write that also registers
// the result, with busy high, before the next transaction can be taken; the
// read then write of the use table sets these steps. A clear walks the table
// one entry per cycle, then passes the update step. After reset the same walk
// runs with busy high before the first transaction is taken.
module node_use_tracker
   import nut_pkg::*;
#(
   parameter int unsigned ID_SPACE = ID_SPACE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  nut_req_type req_data,
   output logic        rsp_strobe,
   output nut_rsp_type rsp_data
);

   nut_cmd_type cmd;
   nut_sts_type sts;

   nut_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   nut_datapath #(
      .ID_SPACE (ID_SPACE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/nut_ctrl.sv =====
// controller state machine for the node use tracker
// depends on nut_pkg; drives nut_datapath through nut_cmd_type
module nut_ctrl
   import nut_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KIND_W-1:0] req_kind,
   input  nut_sts_type       sts,
   output nut_cmd_type       cmd,
   output logic              busy
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   assign accept = start & ~busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = (req_kind == KIND_CLEAR) ? ST_CLEAR : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (sts.sweep_last) state_in = ST_UPDATE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign cmd.load        = accept;
   assign cmd.mem_read    = (state_ff == ST_LOOKUP);
   assign cmd.update      = (state_ff == ST_UPDATE);
   assign cmd.sweep_write = (state_ff == ST_INIT) | (state_ff == ST_CLEAR);
   assign busy            = busy_ff;

endmodule

// ===== design/nut_datapath.sv =====
// use table memory, counters and result register of the node use tracker
// depends on nut_pkg; commanded by nut_ctrl
module nut_datapath
   import nut_pkg::*;
#(
   parameter int unsigned ID_SPACE = ID_SPACE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  nut_req_type req_data,
   input  nut_cmd_type cmd,
   output nut_sts_type sts,
   output logic        rsp_strobe,
   output nut_rsp_type rsp_data
);

   localparam int unsigned ADDR_W = $clog2(ID_SPACE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ID_SPACE - 1);

   logic [USE_W-1:0]  mem [ID_SPACE];

   nut_req_type       req_ff;
   logic              oor_ff;
   logic [USE_W-1:0]  rd_ff;
   logic [ADDR_W-1:0] sweep_addr_ff;
   logic [CNT_W-1:0]  distinct_ff, distinct_in;
   logic [CNT_W-1:0]  repeat_ff, repeat_in;
   logic              rsp_valid_ff;
   nut_rsp_type       rsp_ff, rsp_in;

   logic [ADDR_W-1:0] idx;
   logic              is_mark, is_query, is_clear;
   logic              bump_distinct, bump_repeat;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [USE_W-1:0]  wr_data;

   assign idx      = req_ff.node_id[ADDR_W-1:0];
   assign is_mark  = (req_ff.kind == KIND_MARK);
   assign is_query = (req_ff.kind == KIND_QUERY);
   assign is_clear = (req_ff.kind == KIND_CLEAR);

   assign bump_distinct = cmd.update & is_mark & ~oor_ff & (rd_ff == USE_NONE);
   assign bump_repeat   = cmd.update & is_mark & ~oor_ff & (rd_ff == USE_ONCE);

   assign wr_en   = cmd.sweep_write | bump_distinct | bump_repeat;
   assign wr_addr = cmd.sweep_write ? sweep_addr_ff : idx;
   assign wr_data = cmd.sweep_write ? USE_NONE : (bump_distinct ? USE_ONCE : USE_MANY);

   always_comb begin
      distinct_in = distinct_ff;
      repeat_in   = repeat_ff;
      if (cmd.update && is_clear) begin
         distinct_in = '0;
         repeat_in   = '0;
      end else begin
         if (bump_distinct && distinct_ff != CNT_MAX) distinct_in = distinct_ff + 1'b1;
         if (bump_repeat && repeat_ff != CNT_MAX) repeat_in = repeat_ff + 1'b1;
      end
      rsp_in.used_twice     = is_query & ~oor_ff & (rd_ff >= USE_MANY);
      rsp_in.out_of_range   = (is_mark | is_query) & oor_ff;
      rsp_in.distinct_count = distinct_in;
      rsp_in.repeat_count   = repeat_in;
   end

   // table storage, no reset: the sweep after reset zeroes it
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) rd_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         oor_ff <= (req_data.node_id >= ID_W'(ID_SPACE));
      end
      if (cmd.update) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
         distinct_ff   <= '0;
         repeat_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_write) begin
            sweep_addr_ff <= (sweep_addr_ff == LAST_ADDR) ? '0 : sweep_addr_ff + 1'b1;
         end
         distinct_ff  <= distinct_in;
         repeat_ff    <= repeat_in;
         rsp_valid_ff <= cmd.update;
      end
   end

   assign sts.sweep_last = (sweep_addr_ff == LAST_ADDR);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

`ifndef SYNTHESIS
   a_repeat_le_distinct: assert property (@(posedge clock) disable iff (reset)
      repeat_ff <= distinct_ff)
      else $error("repeat count exceeds distinct count");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.update && (cmd.sweep_write || cmd.mem_read)))
      else $error("update overlaps sweep or lookup");

   a_distinct_step: assert property (@(posedge clock) disable iff (reset)
      bump_distinct && distinct_ff != CNT_MAX |=>
         distinct_ff == CNT_W'($past(distinct_ff) + 1'b1))
      else $error("first mark did not advance distinct count");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      cmd.update && is_clear |=>
         rsp_valid_ff && distinct_ff == '0 && repeat_ff == '0)
      else $error("clear left counters nonzero");
`endif

endmodule
